// ===== rtl/sbus_frame_decoder_macros.svh =====
// Assertion macros shared by the frame decoder modules.
// Depends on nothing; included by files that carry assertions.
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// Implication checked in the same cycle.
`define SFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sfd_pkg.sv =====
// Shared types and constants of the serial-bus frame decoder.
// Depends on nothing; used by every module of the decoder.
`default_nettype none

package sfd_pkg;

   localparam int NUM_CHANNELS  = 16;
   localparam int CHAN_BITS     = 11;
   localparam int CHAN_IDX_BITS = 4;
   localparam int FAILSAFE_BIT  = 3;

   localparam logic [7:0] HEADER_BYTE = 8'h0F;
   localparam logic [7:0] END_BYTE    = 8'h00;

   localparam logic [4:0] PHASE_WAIT      = 5'd0;
   localparam logic [4:0] PHASE_DATA_LAST = 5'd22;
   localparam logic [4:0] PHASE_FLAGS     = 5'd23;
   localparam logic [4:0] PHASE_END       = 5'd24;

   localparam logic [3:0] SHIFT_MAX   = 4'd10;
   localparam logic [4:0] CHAN_BITS_W = 5'd11;
   localparam logic [4:0] FULL_COUNT  = 5'd16;
   localparam logic [3:0] LAST_INDEX  = 4'd15;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       gap_exceeded;
      logic       rx_error;
   } req_type;

   typedef struct packed {
      logic [3:0]  channel_index;
      logic [10:0] channel_value;
      logic        signal_valid;
      logic        last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic                                      failsafe;
      logic [NUM_CHANNELS-1:0][CHAN_BITS-1:0]    chans;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== rtl/sfd_front.sv =====
// Byte parser: header hunt, 11-bit channel unpacking, flag byte, end byte.
// Depends on sfd_pkg and the assertion macro header; feeds sfd_queue.
`default_nettype none
`include "sbus_frame_decoder_macros.svh"

module sfd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire sfd_pkg::req_type   req_data,
   input  wire sfd_pkg::q_status_type q_status,
   output logic                    frame_push,
   output sfd_pkg::frame_type      frame_data
);

   logic [4:0]  phase_ff, phase_in;
   logic [3:0]  pend_ff, pend_in;
   logic [10:0] part_ff, part_in;
   logic [4:0]  nch_ff, nch_in;
   logic        fs_ff, fs_in;
   logic [10:0] store_ff [sfd_pkg::NUM_CHANNELS];

   logic        accept;
   logic        clr;
   logic [4:0]  phase;
   logic [3:0]  pend;
   logic [10:0] part;
   logic [4:0]  nch;
   logic [3:0]  sh;
   logic [4:0]  sh8;
   logic [17:0] acc;
   logic        wr_en;
   logic [3:0]  wr_idx;

   assign accept = req_push && !q_status.full;
   assign clr    = req_data.gap_exceeded || req_data.rx_error;

   always_comb begin
      phase = clr ? sfd_pkg::PHASE_WAIT : phase_ff;
      pend  = clr ? 4'd0 : pend_ff;
      part  = clr ? 11'd0 : part_ff;
      nch   = clr ? 5'd0 : nch_ff;
      sh    = (pend > sfd_pkg::SHIFT_MAX) ? sfd_pkg::SHIFT_MAX : pend;
      sh8   = {1'b0, sh} + 5'd8;
      acc   = {7'd0, part} | ({10'd0, req_data.rx_byte} << sh);
      wr_idx = nch[3:0];

      phase_in   = phase_ff;
      pend_in    = pend_ff;
      part_in    = part_ff;
      nch_in     = nch_ff;
      fs_in      = fs_ff;
      wr_en      = 1'b0;
      frame_push = 1'b0;

      if (accept) begin
         phase_in = phase;
         pend_in  = pend;
         part_in  = part;
         nch_in   = nch;
         if (phase == sfd_pkg::PHASE_WAIT) begin
            if (req_data.rx_byte == sfd_pkg::HEADER_BYTE) begin
               phase_in = phase + 5'd1;
            end
         end else if (phase <= sfd_pkg::PHASE_DATA_LAST) begin
            // a channel completes once eleven bits are gathered
            if (sh8 >= sfd_pkg::CHAN_BITS_W) begin
               wr_en   = 1'b1;
               nch_in  = nch + 5'd1;
               part_in = {4'd0, acc[17:11]};
               pend_in = 4'(sh8 - sfd_pkg::CHAN_BITS_W);
            end else begin
               part_in = acc[10:0];
               pend_in = sh8[3:0];
            end
            phase_in = phase + 5'd1;
         end else if (phase == sfd_pkg::PHASE_FLAGS) begin
            fs_in    = req_data.rx_byte[sfd_pkg::FAILSAFE_BIT];
            phase_in = sfd_pkg::PHASE_END;
         end else begin
            // skip non-zero bytes until the end byte
            if (req_data.rx_byte == sfd_pkg::END_BYTE) begin
               frame_push = 1'b1;
               phase_in   = sfd_pkg::PHASE_WAIT;
               pend_in    = 4'd0;
               part_in    = 11'd0;
               nch_in     = 5'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfd_pkg::PHASE_WAIT;
         pend_ff  <= 4'd0;
         part_ff  <= 11'd0;
         nch_ff   <= 5'd0;
         fs_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         part_ff  <= part_in;
         nch_ff   <= nch_in;
         fs_ff    <= fs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= acc[10:0];
      end
   end

   always_comb begin
      frame_data.failsafe = fs_ff;
      for (int i = 0; i < sfd_pkg::NUM_CHANNELS; i++) begin
         frame_data.chans[i] = store_ff[i];
      end
   end

   `SFD_ASSERT_NOW(a_flags_after_full_data, clock, reset,
      phase_ff == sfd_pkg::PHASE_FLAGS,
      nch_ff == sfd_pkg::FULL_COUNT && pend_ff == 4'd0,
      "flag byte reached without sixteen whole channels")
   `SFD_ASSERT_NOW(a_push_only_at_end, clock, reset,
      frame_push,
      !clr ? phase_ff >= sfd_pkg::PHASE_END : 1'b0,
      "frame pushed outside the end phase")

endmodule

`default_nettype wire

// ===== rtl/sfd_queue.sv =====
// Two-entry queue of decoded frames between the parser and the emitter.
// Depends on sfd_pkg and the assertion macro header.
`default_nettype none
`include "sbus_frame_decoder_macros.svh"

module sfd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sfd_pkg::frame_type push_data,
   input  wire logic               pop,
   output sfd_pkg::frame_type      head_data,
   output sfd_pkg::q_status_type   status
);

   sfd_pkg::frame_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SFD_ASSERT_NOW(a_count_bound, clock, reset,
      1'b1, count_ff <= 2'd2, "frame queue count out of range")
   `SFD_ASSERT_NOW(a_ptr_track, clock, reset,
      count_ff == 2'd0 || count_ff == 2'd2, wr_ptr_ff == rd_ptr_ff,
      "queue pointers disagree with count")

endmodule

`default_nettype wire

// ===== rtl/sfd_back.sv =====
// Result emitter: walks the sixteen channels of the head frame into a
// result register. Depends on sfd_pkg and the assertion macro header.
`default_nettype none
`include "sbus_frame_decoder_macros.svh"

module sfd_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sfd_pkg::frame_type    head_data,
   input  wire sfd_pkg::q_status_type q_status,
   output logic                       q_pop,
   input  wire logic                  rsp_pop,
   output logic                       rsp_empty,
   output sfd_pkg::rsp_type           rsp_data
);

   logic [3:0]       cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   sfd_pkg::rsp_type out_ff, out_in;
   logic             taken;
   logic             load;

   assign taken = rsp_pop && valid_ff;
   assign load  = !q_status.empty && (!valid_ff || taken);

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      q_pop    = 1'b0;
      if (taken) begin
         valid_in = 1'b0;
      end
      if (load) begin
         out_in.channel_index = cnt_ff;
         out_in.channel_value = head_data.chans[cnt_ff];
         out_in.signal_valid  = !head_data.failsafe;
         out_in.last_of_frame = (cnt_ff == sfd_pkg::LAST_INDEX);
         valid_in = 1'b1;
         cnt_in   = cnt_ff + 4'd1;
         // release the frame after its last channel
         q_pop    = (cnt_ff == sfd_pkg::LAST_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

   `SFD_ASSERT_NOW(a_frame_held, clock, reset,
      cnt_ff != 4'd0, !q_status.empty, "frame left the queue mid-walk")
   `SFD_ASSERT_NOW(a_last_index, clock, reset,
      valid_ff && out_ff.last_of_frame, out_ff.channel_index == sfd_pkg::LAST_INDEX,
      "last mark on a channel other than fifteen")

endmodule

`default_nettype wire

// ===== rtl/sbus_frame_decoder.sv =====
// Serial-bus RC frame decoder. One received byte is taken per clock whenever
// req_full is low; the parser keeps no multi-cycle work per byte. A zero end
// byte after a complete frame snapshots the sixteen 11-bit channels into a
// two-frame queue, and the emitter then delivers them as sixteen words, one
// per clock while rsp_pop is high, channel 0 first, last_of_frame on
// channel 15. req_full rises only while two decoded frames are still
// waiting to be emitted.
`default_nettype none

module sbus_frame_decoder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire sfd_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output sfd_pkg::rsp_type      rsp_data
);

   sfd_pkg::frame_type    frame_data;
   sfd_pkg::frame_type    head_data;
   sfd_pkg::q_status_type q_status;
   logic                  frame_push;
   logic                  q_pop;

   assign req_full = q_status.full;

   sfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .q_status   (q_status),
      .frame_push (frame_push),
      .frame_data (frame_data)
   );

   sfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (frame_data),
      .pop       (q_pop),
      .head_data (head_data),
      .status    (q_status)
   );

   sfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== verif/tb_sbus_frame_decoder.sv =====
// Self-checking testbench for sbus_frame_decoder: directed frames from a table, then random
// well-formed, broken and noisy byte streams, each checked against a cycle-free decoder model.
// Depends on sfd_pkg and the sbus_frame_decoder RTL.
`default_nettype none

module tb_sbus_frame_decoder;

   localparam int RUN_LIMIT    = 200000;
   localparam int ITEM_TARGET  = 430;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [4:0] NO_ABORT = 5'd31;

   // One frame to send. abort_at: data bytes sent before giving up (22 = stop before the
   // flag byte, 23 = stop before the end byte). Typed rows carry their expected channels.
   typedef struct packed {
      logic        rand_data;
      logic [7:0]  fill;
      logic [7:0]  flag_byte;
      logic [1:0]  hdr_flags;   // {gap, error}
      logic [4:0]  abort_at;
      logic [1:0]  n_skip;
      logic [1:0]  end_flags;   // {gap, error}
      logic        typed;
      logic [10:0] t_value;
      logic        t_valid;
   } frame_plan_type;

   localparam int NUM_DIRECTED = 13;
   localparam frame_plan_type DIRECTED_FRAMES [NUM_DIRECTED] = '{
      '{1'b0, 8'h00, 8'h00, 2'b00, NO_ABORT, 2'd0, 2'b00, 1'b1, 11'h000, 1'b1},
      '{1'b0, 8'hFF, 8'h08, 2'b00, NO_ABORT, 2'd0, 2'b00, 1'b1, 11'h7FF, 1'b0},
      '{1'b0, 8'hFF, 8'hF7, 2'b00, NO_ABORT, 2'd0, 2'b00, 1'b1, 11'h7FF, 1'b1},
      '{1'b0, 8'h00, 8'hFF, 2'b10, NO_ABORT, 2'd0, 2'b00, 1'b1, 11'h000, 1'b0},
      '{1'b0, 8'h0F, 8'h00, 2'b01, NO_ABORT, 2'd3, 2'b00, 1'b0, 11'h000, 1'b0},
      '{1'b1, 8'h00, 8'h04, 2'b00, 5'd7,     2'd0, 2'b00, 1'b0, 11'h000, 1'b0},
      '{1'b1, 8'h00, 8'h00, 2'b10, NO_ABORT, 2'd0, 2'b00, 1'b0, 11'h000, 1'b0},
      '{1'b0, 8'hAA, 8'h00, 2'b00, 5'd22,    2'd0, 2'b00, 1'b0, 11'h000, 1'b0},
      '{1'b1, 8'h00, 8'h08, 2'b01, NO_ABORT, 2'd1, 2'b00, 1'b0, 11'h000, 1'b0},
      '{1'b1, 8'h00, 8'h00, 2'b00, 5'd23,    2'd0, 2'b00, 1'b0, 11'h000, 1'b0},
      '{1'b1, 8'h00, 8'h00, 2'b10, NO_ABORT, 2'd1, 2'b10, 1'b0, 11'h000, 1'b0},
      '{1'b0, 8'h55, 8'h00, 2'b11, NO_ABORT, 2'd0, 2'b00, 1'b0, 11'h000, 1'b0},
      '{1'b0, 8'h80, 8'h08, 2'b00, NO_ABORT, 2'd2, 2'b01, 1'b0, 11'h000, 1'b0}
   };

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   logic             req_full;
   sfd_pkg::req_type req_word  = '0;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   sfd_pkg::rsp_type rsp_word;

   // decoder model state
   logic [4:0]       exp_phase     = sfd_pkg::PHASE_WAIT;
   logic [3:0]       exp_held_bits = '0;
   logic [10:0]      exp_partial   = '0;
   logic [4:0]       exp_chan_ptr  = '0;
   logic [10:0]      exp_chan_store [sfd_pkg::NUM_CHANNELS];
   logic             exp_failsafe  = 1'b0;
   sfd_pkg::rsp_type pending_channels [$];

   int mismatches  = 0;
   int cycle_count = 0;
   int items_sent  = 0;
   bit gaps_on     = 1'b1;
   int burst_left  = 0;
   int hold_asks   = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   logic [7:0] rx_cycle = '0;

   sbus_frame_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_word)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("sbus_frame_decoder regression: fail");
         $finish;
      end
   end

   function automatic void clear_frame_state();
      exp_phase     = sfd_pkg::PHASE_WAIT;
      exp_held_bits = '0;
      exp_partial   = '0;
      exp_chan_ptr  = '0;
   endfunction

   // Advance the decoder model by one byte; a good end byte queues sixteen channel words.
   function automatic void decode_sbus_byte(input sfd_pkg::req_type w);
      int               shift;
      logic [18:0]      acc;
      sfd_pkg::rsp_type word;
      if (w.gap_exceeded || w.rx_error) clear_frame_state();
      if (exp_phase == sfd_pkg::PHASE_WAIT) begin
         if (w.rx_byte == sfd_pkg::HEADER_BYTE) exp_phase = sfd_pkg::PHASE_WAIT + 5'd1;
      end else if (exp_phase <= sfd_pkg::PHASE_DATA_LAST) begin
         shift = int'(exp_held_bits);
         if (shift > sfd_pkg::CHAN_BITS - 1) shift = sfd_pkg::CHAN_BITS - 1;
         acc = 19'(exp_partial) | (19'(w.rx_byte) << shift);
         if (shift + 8 >= sfd_pkg::CHAN_BITS) begin
            exp_chan_store[exp_chan_ptr[3:0]] = acc[10:0];
            exp_chan_ptr  = exp_chan_ptr + 5'd1;
            exp_partial   = 11'(acc[18:11]);
            exp_held_bits = 4'(shift + 8 - sfd_pkg::CHAN_BITS);
         end else begin
            exp_partial   = acc[10:0];
            exp_held_bits = 4'(shift + 8);
         end
         exp_phase = exp_phase + 5'd1;
      end else if (exp_phase == sfd_pkg::PHASE_FLAGS) begin
         exp_failsafe = w.rx_byte[sfd_pkg::FAILSAFE_BIT];
         exp_phase    = sfd_pkg::PHASE_END;
      end else if (w.rx_byte == sfd_pkg::END_BYTE) begin
         for (int k = 0; k < sfd_pkg::NUM_CHANNELS; k++) begin
            word.channel_index = 4'(k);
            word.channel_value = exp_chan_store[k];
            word.signal_valid  = ~exp_failsafe;
            word.last_of_frame = (k == sfd_pkg::NUM_CHANNELS - 1);
            pending_channels.push_back(word);
         end
         clear_frame_state();
      end
   endfunction

   // Offer one byte, wait for the handshake, then update the model.
   task automatic send_word(input sfd_pkg::req_type w, input logic typed,
                            input logic [10:0] t_value, input logic t_valid);
      int               n_prior;
      sfd_pkg::rsp_type word;
      @(negedge clock);
      if (gaps_on && burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_push <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
      n_prior = pending_channels.size();
      decode_sbus_byte(w);
      if (typed && pending_channels.size() == n_prior + sfd_pkg::NUM_CHANNELS) begin
         for (int k = n_prior; k < pending_channels.size(); k++) begin
            word = pending_channels[k];
            word.channel_value = t_value;
            word.signal_valid  = t_valid;
            pending_channels[k] = word;
         end
      end
   endtask

   task automatic send_plain(input logic [7:0] b, input logic gap, input logic err);
      send_word(sfd_pkg::req_type'{rx_byte: b, gap_exceeded: gap, rx_error: err},
                1'b0, '0, 1'b0);
   endtask

   task automatic send_frame(input frame_plan_type plan);
      send_plain(sfd_pkg::HEADER_BYTE, plan.hdr_flags[1], plan.hdr_flags[0]);
      for (int i = 0; i < 22; i++) begin
         if (i == plan.abort_at) return;
         send_plain(plan.rand_data ? 8'($urandom) : plan.fill, 1'b0, 1'b0);
      end
      if (plan.abort_at == 5'd22) return;
      send_plain(plan.flag_byte, 1'b0, 1'b0);
      if (plan.abort_at == 5'd23) return;
      repeat (plan.n_skip) send_plain(8'($urandom_range(1, 255)), 1'b0, 1'b0);
      send_word(sfd_pkg::req_type'{rx_byte: sfd_pkg::END_BYTE,
                                   gap_exceeded: plan.end_flags[1],
                                   rx_error: plan.end_flags[0]},
                plan.typed, plan.t_value, plan.t_valid);
   endtask

   // Drop push and hold until every predicted channel word has come out.
   task automatic drain_channels();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_channels.size() != 0) @(posedge clock);
   endtask

   function automatic frame_plan_type random_plan(input int kind);
      frame_plan_type plan;
      plan.rand_data = ($urandom_range(0, 7) != 0);
      plan.fill      = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      plan.flag_byte = 8'($urandom);
      plan.hdr_flags = ($urandom_range(0, 1) != 0) ? 2'($urandom_range(1, 3)) : 2'b00;
      plan.abort_at  = (kind == 7) ? 5'($urandom_range(0, 23)) : NO_ABORT;
      plan.n_skip    = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
      plan.end_flags = (kind == 8) ? 2'($urandom_range(1, 3)) : 2'b00;
      plan.typed     = 1'b0;
      plan.t_value   = '0;
      plan.t_valid   = 1'b0;
      return plan;
   endfunction

   // Receiver: its own stall pattern, plus a long hold-off on request.
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 8'd1;
      if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_pop   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else begin
         case (rx_cycle[7:6])
            2'd0: rsp_pop <= 1'b1;
            2'd1: rsp_pop <= 1'($urandom);
            2'd2: rsp_pop <= (rx_cycle[1:0] == 2'd0);
            default: rsp_pop <= rx_cycle[3];
         endcase
      end
   end

   always @(posedge clock) begin
      sfd_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_channels.size() == 0) begin
            $error("unexpected channel word: index %0d value %0h",
                   rsp_word.channel_index, rsp_word.channel_value);
            mismatches++;
         end else begin
            want = pending_channels.pop_front();
            if (rsp_word.channel_index !== want.channel_index) begin
               $error("channel_index: expected %0d, got %0d",
                      want.channel_index, rsp_word.channel_index);
               mismatches++;
            end
            if (rsp_word.channel_value !== want.channel_value) begin
               $error("channel_value: expected %0h, got %0h",
                      want.channel_value, rsp_word.channel_value);
               mismatches++;
            end
            if (rsp_word.signal_valid !== want.signal_valid) begin
               $error("signal_valid: expected %0b, got %0b",
                      want.signal_valid, rsp_word.signal_valid);
               mismatches++;
            end
            if (rsp_word.last_of_frame !== want.last_of_frame) begin
               $error("last_of_frame: expected %0b, got %0b",
                      want.last_of_frame, rsp_word.last_of_frame);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int kind;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bytes seen while waiting for a header, the end byte among them, are dropped
      send_plain(sfd_pkg::END_BYTE, 1'b0, 1'b0);
      send_plain(8'hFF, 1'b0, 1'b0);
      send_plain(8'hF0, 1'b1, 1'b1);
      for (int r = 0; r < NUM_DIRECTED; r++) send_frame(DIRECTED_FRAMES[r]);
      drain_channels();

      // long receiver hold-off while back-to-back frames pile up behind req_full
      hold_asks++;
      gaps_on = 1'b0;
      repeat (3) send_frame(random_plan(0));
      gaps_on = 1'b1;

      while (items_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
         if (kind == 9) begin
            repeat ($urandom_range(1, 6))
               send_plain(8'($urandom), ($urandom_range(0, 3) == 0),
                          ($urandom_range(0, 3) == 0));
         end else begin
            send_frame(random_plan(kind));
         end
      end

      drain_channels();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_channels.size() == 0)
         $display("sbus_frame_decoder regression: pass");
      else
         $display("sbus_frame_decoder regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_front.sv
rtl/sfd_queue.sv
rtl/sfd_back.sv
rtl/sbus_frame_decoder.sv
verif/tb_sbus_frame_decoder.sv
